/* hw/rtl/mrp_pkg.sv */
// ============================================================================
// mrp_pkg
// shared constants, codes and types for the macro record/playback block
// ============================================================================
`timescale 1ns / 1ps

package mrp_pkg;

  // store geometry
  localparam int ENTRIES       = 256;
  localparam int COMMAND_BYTES = 8;
  localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ENTRIES + 1);

  // field widths
  localparam int OP_W      = 4;
  localparam int CMD_W     = 64;
  localparam int STORE_W   = 8 * COMMAND_BYTES;
  localparam int STAMP_W   = 32;
  localparam int MODE_W    = 2;

  // stream widths, padded to whole bytes
  localparam int IN_USED_W    = OP_W + CMD_W + STAMP_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W   = MODE_W + CMD_W + STAMP_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_RECORD      = 4'd0;
  localparam logic [OP_W-1:0] OP_REC_START   = 4'd1;
  localparam logic [OP_W-1:0] OP_REC_STOP    = 4'd2;
  localparam logic [OP_W-1:0] OP_REC_TOGGLE  = 4'd3;
  localparam logic [OP_W-1:0] OP_PLAY_START  = 4'd4;
  localparam logic [OP_W-1:0] OP_PLAY_STOP   = 4'd5;
  localparam logic [OP_W-1:0] OP_PLAY_TOGGLE = 4'd6;
  localparam logic [OP_W-1:0] OP_NEXT        = 4'd7;
  localparam logic [OP_W-1:0] OP_QUERY       = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_t;

  // access to the command/stamp store
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   addr;
    logic [STORE_W-1:0] wr_cmd;
    logic [STAMP_W-1:0] wr_stamp;
  } store_req_t;

endpackage

/* hw/rtl/mrp_store.sv */
// ============================================================================
// mrp_store
// command and tick stamp memories, one access per cycle, registered read
// ============================================================================
`timescale 1ns / 1ps

module mrp_store
  import mrp_pkg::*;
(
  input  logic               clk,
  input  store_req_t         req,
  output logic [STORE_W-1:0] rd_cmd,
  output logic [STAMP_W-1:0] rd_stamp
);

  logic [STORE_W-1:0] cmd_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      cmd_mem[req.addr]   <= req.wr_cmd;
      stamp_mem[req.addr] <= req.wr_stamp;
    end
    if (req.rd_en) begin
      rd_cmd   <= cmd_mem[req.addr];
      rd_stamp <= stamp_mem[req.addr];
    end
  end

endmodule

/* hw/rtl/mrp_ctrl.sv */
// ============================================================================
// mrp_ctrl
// mode sequencer, store addressing and output register
// ============================================================================
`timescale 1ns / 1ps

module mrp_ctrl
  import mrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [CMD_W-1:0]   command_word,
  input  logic [STAMP_W-1:0] tick_now,
  // store
  output store_req_t         store_req,
  input  logic [STORE_W-1:0] rd_cmd,
  input  logic [STAMP_W-1:0] rd_stamp,
  // result side
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MODE_W-1:0]  mode_after,
  output logic               action_valid,
  output logic [CMD_W-1:0]   action_command,
  output logic [STAMP_W-1:0] action_delay,
  output logic               last_action
);

  typedef enum logic {
    ST_TAKE,
    ST_READ
  } state_t;

  state_t             state;
  mode_t              mode;
  logic [CNT_W-1:0]   record_count;
  logic [CNT_W-1:0]   play_index;
  logic [STAMP_W-1:0] last_stamp;
  logic               pend_first;
  logic               pend_last;

  mode_t              mode_next;
  logic [CNT_W-1:0]   record_count_next;
  logic [CNT_W-1:0]   play_index_next;
  logic               wr_en;
  logic               rd_en;
  logic               is_last;
  logic               accept;
  logic               out_free;
  logic [STAMP_W-1:0] prev_stamp;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_TAKE) && out_free;
  assign accept   = in_valid && in_ready;

  // decode of one request against the current mode
  always_comb begin
    mode_next         = mode;
    record_count_next = record_count;
    play_index_next   = play_index;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    is_last           = 1'b0;
    case (operation)
      OP_RECORD: begin
        if (mode == MODE_RECORD) begin
          if (record_count < CNT_W'(ENTRIES)) begin
            wr_en             = 1'b1;
            record_count_next = record_count + 1'b1;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
      end
      OP_REC_START: begin
        if (mode == MODE_IDLE) begin
          mode_next         = MODE_RECORD;
          record_count_next = '0;
        end
      end
      OP_REC_STOP: begin
        if (mode == MODE_RECORD) mode_next = MODE_IDLE;
      end
      OP_REC_TOGGLE: begin
        if (mode == MODE_IDLE) begin
          mode_next         = MODE_RECORD;
          record_count_next = '0;
        end else if (mode == MODE_RECORD) begin
          mode_next = MODE_IDLE;
        end
      end
      OP_PLAY_START: begin
        if (mode == MODE_IDLE) begin
          mode_next       = MODE_PLAY;
          play_index_next = '0;
        end
      end
      OP_PLAY_STOP: begin
        if (mode == MODE_PLAY) mode_next = MODE_IDLE;
      end
      OP_PLAY_TOGGLE: begin
        if (mode == MODE_IDLE) begin
          mode_next       = MODE_PLAY;
          play_index_next = '0;
        end else if (mode == MODE_PLAY) begin
          mode_next = MODE_IDLE;
        end
      end
      OP_NEXT: begin
        if (mode == MODE_PLAY) begin
          if (play_index < record_count) begin
            rd_en           = 1'b1;
            play_index_next = play_index + 1'b1;
            if (play_index_next >= record_count) begin
              mode_next = MODE_IDLE;
              is_last   = 1'b1;
            end
          end else begin
            mode_next = MODE_IDLE;
          end
        end
      end
      default: ; // query and unused codes leave everything alone
    endcase
  end

  always_comb begin
    store_req.wr_en    = accept && wr_en;
    store_req.rd_en    = accept && rd_en;
    store_req.addr     = rd_en ? play_index[IDX_W-1:0] : record_count[IDX_W-1:0];
    store_req.wr_cmd   = command_word[STORE_W-1:0];
    store_req.wr_stamp = tick_now;
  end

  assign prev_stamp = pend_first ? rd_stamp : last_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_TAKE;
      mode         <= MODE_IDLE;
      record_count <= '0;
      play_index   <= '0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        ST_TAKE: begin
          if (accept) begin
            mode         <= mode_next;
            record_count <= record_count_next;
            play_index   <= play_index_next;
            pend_first   <= (play_index == '0);
            pend_last    <= is_last;
            mode_after   <= mode_next;
            if (rd_en) begin
              state     <= ST_READ;
              out_valid <= 1'b0;
            end else begin
              out_valid      <= 1'b1;
              action_valid   <= 1'b0;
              action_command <= '0;
              action_delay   <= '0;
              last_action    <= 1'b0;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_READ: begin
          // store data is here; the output register was freed on accept
          state          <= ST_TAKE;
          out_valid      <= 1'b1;
          action_valid   <= 1'b1;
          action_command <= CMD_W'(rd_cmd);
          action_delay   <= rd_stamp - prev_stamp;
          last_action    <= pend_last;
          last_stamp     <= rd_stamp;
        end
        default: state <= ST_TAKE;
      endcase
    end
  end

  // a pending read always completes, leaving ST_READ in the next cycle
  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_TAKE)
    else $error("store read held over");

  // playback never runs past the recorded entries
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_PLAY |-> play_index <= record_count)
    else $error("play index beyond record count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= CNT_W'(ENTRIES))
    else $error("record count beyond store depth");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && state == ST_TAKE |-> !accept)
    else $error("result overwritten while stalled");

  // results without an action carry zero payload
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !action_valid |-> action_command == '0 && action_delay == '0
      && !last_action)
    else $error("non-action result with payload");

endmodule

/* hw/rtl/macro_record_playback_top.sv */
// ============================================================================
// macro_record_playback_top
// macro recorder: records command words with tick stamps, plays them back
// ============================================================================
`timescale 1ns / 1ps
//
// channel   | direction | signals                        | contents
// ----------+-----------+--------------------------------+-------------------------------
// s_        | in        | tvalid, tready, tdata          | one request (operation, command,
//           |           |                                | tick)
// m_        | out       | tvalid, tready, tdata, tuser,  | one result per request
//           |           | tlast                          |
//
// flow: every request yields exactly one result. a next request that plays a stored
// action goes through the read state (synchronous read of the command and stamp
// memories) before the output register; all other requests load it directly.
// a new request is taken while the previous result is being taken downstream.
// reset: synchronous, clears mode to idle, record count and play index to zero;
// the memories are not cleared and are only ever read below the record count.
// stalls: a held result blocks new requests until it is taken; a pending
// memory read always completes the following cycle.

module macro_record_playback_top
  import mrp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [3:0] operation, [67:4] command_word, [99:68] tick_now, rest zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] mode_after, [65:2] action_command, [97:66] action_delay, rest zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // [0] action_valid
  output logic [0:0]             m_tuser,
  // last_action
  output logic                   m_tlast
);

  // unpacked request fields
  logic [OP_W-1:0]    operation;
  logic [CMD_W-1:0]   command_word;
  logic [STAMP_W-1:0] tick_now;

  // result fields
  logic [MODE_W-1:0]  mode_after;
  logic               action_valid;
  logic [CMD_W-1:0]   action_command;
  logic [STAMP_W-1:0] action_delay;

  // store access
  store_req_t         store_req;
  logic [STORE_W-1:0] rd_cmd;
  logic [STAMP_W-1:0] rd_stamp;

  assign operation    = s_tdata[OP_W-1:0];
  assign command_word = s_tdata[OP_W +: CMD_W];
  assign tick_now     = s_tdata[OP_W + CMD_W +: STAMP_W];

  mrp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .operation      (operation),
    .command_word   (command_word),
    .tick_now       (tick_now),
    .store_req      (store_req),
    .rd_cmd         (rd_cmd),
    .rd_stamp       (rd_stamp),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .mode_after     (mode_after),
    .action_valid   (action_valid),
    .action_command (action_command),
    .action_delay   (action_delay),
    .last_action    (m_tlast)
  );

  // command and stamp memories share one address per cycle
  mrp_store u_store (
    .clk      (clk),
    .req      (store_req),
    .rd_cmd   (rd_cmd),
    .rd_stamp (rd_stamp)
  );

  // pack the result; unused top bits are zero
  assign m_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, action_delay, action_command,
                    mode_after};
  assign m_tuser = action_valid;

endmodule

/* tb/macro_record_playback_top_tb.sv */
// ============================================================================
// macro_record_playback_top_tb
// self-checking bench: directed table then random record/play sessions,
// every result compared against the table's expected result for typed rows,
// else against a cycle-free model of the recorder
`timescale 1ns / 1ps

module macro_record_playback_top_tb;
  import mrp_pkg::*;

  // operation codes past query behave as a query
  localparam logic [OP_W-1:0] OP_RESERVED_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 4'd15;

  localparam int ITEMS        = 650;
  localparam int CALM_TAIL    = 60;     // requests at the end with no idling
  localparam int HOLD_AFTER   = 150;    // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    mode_t              mode;
    bit                 valid;
    bit [CMD_W-1:0]     command;
    bit [STAMP_W-1:0]   delay;
    bit                 last;
  } outcome_t;

  // one request; typed rows carry their expected result
  typedef struct packed {
    logic [OP_W-1:0]    op;
    bit [CMD_W-1:0]     command;
    bit [STAMP_W-1:0]   tick;
    bit                 typed;
    outcome_t           want;
  } request_t;

  localparam bit [CMD_W-1:0] ALL_ONES = '1;
  localparam bit [CMD_W-1:0] PATTERN  = 64'h0123_4567_89AB_CDEF;
  localparam outcome_t IN_IDLE   = '{MODE_IDLE,   1'b0, '0, '0, 1'b0};
  localparam outcome_t IN_RECORD = '{MODE_RECORD, 1'b0, '0, '0, 1'b0};
  localparam outcome_t IN_PLAY   = '{MODE_PLAY,   1'b0, '0, '0, 1'b0};

  localparam int N_DIRECTED = 25;

  // directed table: mode transitions, edge values and the special cases
  request_t directed_rows [N_DIRECTED] = '{
    '{OP_QUERY,       '0,       '0,    1'b1, IN_IDLE},    // state after reset
    '{OP_NEXT,        '0,       '0,    1'b1, IN_IDLE},    // next outside play
    '{OP_PLAY_START,  '0,       '0,    1'b1, IN_PLAY},
    '{OP_NEXT,        '0,       '0,    1'b1, IN_IDLE},    // nothing recorded yet
    '{OP_REC_STOP,    '0,       '0,    1'b1, IN_IDLE},    // stop outside its mode
    '{OP_PLAY_STOP,   '0,       '0,    1'b1, IN_IDLE},
    '{OP_REC_TOGGLE,  '0,       '0,    1'b1, IN_RECORD},  // toggle from idle
    '{OP_REC_START,   '0,       '0,    1'b1, IN_RECORD},  // start outside idle
    '{OP_PLAY_START,  '0,       '0,    1'b1, IN_RECORD},
    '{OP_RECORD,      ALL_ONES, '1,    1'b1, IN_RECORD},  // widest command, top tick
    '{OP_RECORD,      '0,       '0,    1'b1, IN_RECORD},  // tick wraps past zero
    '{OP_RECORD,      PATTERN,  32'd5, 1'b0, IN_IDLE},
    '{OP_PLAY_TOGGLE, '0,       '0,    1'b1, IN_RECORD},  // ignored while recording
    '{OP_PLAY_STOP,   '0,       '0,    1'b1, IN_RECORD},
    '{OP_REC_TOGGLE,  '0,       '0,    1'b1, IN_IDLE},
    '{OP_RECORD,      ALL_ONES, '1,    1'b1, IN_IDLE},    // record outside recording
    '{OP_RESERVED_HI, ALL_ONES, '1,    1'b1, IN_IDLE},
    '{OP_RESERVED_LO, '0,       '0,    1'b1, IN_IDLE},
    '{OP_PLAY_TOGGLE, '0,       '0,    1'b1, IN_PLAY},
    '{OP_NEXT,        '0,       '0,    1'b1,
      '{MODE_PLAY, 1'b1, ALL_ONES, 32'd0, 1'b0}},        // first entry, zero delay
    '{OP_REC_TOGGLE,  '0,       '0,    1'b1, IN_PLAY},
    '{OP_NEXT,        '0,       '0,    1'b1,
      '{MODE_PLAY, 1'b1, 64'd0, 32'd1, 1'b0}},           // delay modulo 2^32
    '{OP_NEXT,        '0,       '0,    1'b0, IN_IDLE},    // last entry back to idle
    '{OP_PLAY_START,  '0,       '0,    1'b1, IN_PLAY},
    '{OP_PLAY_STOP,   '0,       '0,    1'b1, IN_IDLE}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tlast;

  // recorder state as the model sees it
  mode_t                  rec_mode;
  int unsigned            rec_count;
  int unsigned            play_idx;
  bit [CMD_W-1:0]         cmd_mem [ENTRIES];
  bit [STAMP_W-1:0]       stamp_mem [ENTRIES];

  request_t               request_plan [$];
  outcome_t               pending_outcomes [$];
  bit [STAMP_W-1:0]       now_ms;
  int                     mismatches   = 0;
  int                     results_seen = 0;
  int                     cycle_count  = 0;
  bit                     calm         = 1'b0;

  macro_record_playback_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
  end

  // one request through the recorder: updates the state, returns the result
  function automatic outcome_t advance_recorder(input request_t r);
    outcome_t         o;
    bit [CMD_W-1:0]   kept;
    bit [STAMP_W-1:0] prev_stamp;
    o = '{MODE_IDLE, 1'b0, '0, '0, 1'b0};
    kept = '0;
    kept[STORE_W-1:0] = r.command[STORE_W-1:0];
    case (r.op)
      OP_RECORD: begin
        if (rec_mode == MODE_RECORD) begin
          if (rec_count < ENTRIES) begin
            cmd_mem[rec_count]   = kept;
            stamp_mem[rec_count] = r.tick;
            rec_count++;
          end else begin
            rec_mode = MODE_IDLE;       // full store drops the event
          end
        end
      end
      OP_REC_START, OP_REC_TOGGLE: begin
        if (rec_mode == MODE_IDLE) begin
          rec_mode  = MODE_RECORD;
          rec_count = 0;
        end else if (r.op == OP_REC_TOGGLE && rec_mode == MODE_RECORD) begin
          rec_mode = MODE_IDLE;
        end
      end
      OP_REC_STOP: begin
        if (rec_mode == MODE_RECORD) rec_mode = MODE_IDLE;
      end
      OP_PLAY_START, OP_PLAY_TOGGLE: begin
        if (rec_mode == MODE_IDLE) begin
          rec_mode = MODE_PLAY;
          play_idx = 0;
        end else if (r.op == OP_PLAY_TOGGLE && rec_mode == MODE_PLAY) begin
          rec_mode = MODE_IDLE;
        end
      end
      OP_PLAY_STOP: begin
        if (rec_mode == MODE_PLAY) rec_mode = MODE_IDLE;
      end
      OP_NEXT: begin
        if (rec_mode == MODE_PLAY) begin
          if (play_idx < rec_count) begin
            prev_stamp = (play_idx == 0) ? stamp_mem[play_idx] : stamp_mem[play_idx - 1];
            o.valid    = 1'b1;
            o.command  = cmd_mem[play_idx];
            o.delay    = stamp_mem[play_idx] - prev_stamp;
            play_idx++;
            if (play_idx >= rec_count) begin
              rec_mode = MODE_IDLE;
              o.last   = 1'b1;
            end
          end else begin
            rec_mode = MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
    o.mode = rec_mode;
    return o;
  endfunction

  function automatic bit [CMD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // mostly a forward-running clock, now and then a jump anywhere
  function automatic bit [STAMP_W-1:0] advance_tick();
    if ($urandom_range(0, 9) == 0) now_ms = $urandom;
    else now_ms += $urandom_range(0, 3000);
    return now_ms;
  endfunction

  function automatic void add_request(input logic [OP_W-1:0] op,
                                      input bit [CMD_W-1:0] command,
                                      input bit [STAMP_W-1:0] tick);
    request_t r;
    r = '{op, command, tick, 1'b0, IN_IDLE};
    request_plan.push_back(r);
  endfunction

  // record n_rec commands, then play n_play of them; sometimes the stop
  // is left out so playback never starts
  task automatic plan_session(input int n_rec, input int n_play);
    logic [OP_W-1:0] op;
    add_request($urandom_range(0, 1) ? OP_REC_START : OP_REC_TOGGLE,
                random_word(), advance_tick());
    for (int k = 0; k < n_rec; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       op = OP_QUERY;
          1:       op = OP_REC_START;
          2:       op = OP_PLAY_START;
          default: op = OP_NEXT;
        endcase
        add_request(op, random_word(), advance_tick());
      end
      add_request(OP_RECORD, random_word(), advance_tick());
    end
    if ($urandom_range(0, 7) != 0)
      add_request($urandom_range(0, 1) ? OP_REC_STOP : OP_REC_TOGGLE,
                  random_word(), advance_tick());
    add_request($urandom_range(0, 1) ? OP_PLAY_START : OP_PLAY_TOGGLE,
                random_word(), advance_tick());
    for (int k = 0; k < n_play; k++)
      add_request(OP_NEXT, random_word(), advance_tick());
    if (n_play < n_rec)
      add_request($urandom_range(0, 1) ? OP_PLAY_STOP : OP_PLAY_TOGGLE,
                  random_word(), advance_tick());
  endtask

  // cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending",
             cycle_count, pending_outcomes.size());
    $display("*** FAILED ***");
    $finish;
  end

  // request side: table first, then random sessions and noise
  initial begin : request_source
    request_t r;
    outcome_t predicted;
    bit       filled_once;
    int       n_rec;

    now_ms      = $urandom;
    filled_once = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      request_plan.push_back(directed_rows[i]);
    while (request_plan.size() < ITEMS) begin
      if (!filled_once && request_plan.size() > 250) begin
        // fill the whole store and overrun it by two
        plan_session(ENTRIES + 2, 20);
        filled_once = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          add_request(OP_W'($urandom_range(0, 15)), random_word(), $urandom);
      end else begin
        n_rec = $urandom_range(1, 10);
        plan_session(n_rec, $urandom_range(0, n_rec + 2));
      end
    end

    rec_mode  = MODE_IDLE;
    rec_count = 0;
    play_idx  = 0;

    while (rst) @(negedge clk);
    for (int i = 0; i < request_plan.size(); i++) begin
      r    = request_plan[i];
      calm = (i >= request_plan.size() - CALM_TAIL);
      // idle bursts, with every fourth stretch of 50 requests back to back
      if (!calm && (i / 50) % 4 != 3 && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, r.tick, r.command, r.op};
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      predicted = advance_recorder(r);
      pending_outcomes.push_back(r.typed ? r.want : predicted);
      @(negedge clk);
    end
    s_tvalid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // result side: short stall bursts plus one long hold-off that backs up
  // the block while requests keep coming
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && (cycle_count / 200) % 4 != 3 &&
                   $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("result %0d with no request pending: tdata %h", results_seen, m_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tdata[MODE_W-1:0] !== want.mode || m_tuser[0] !== want.valid ||
            m_tdata[MODE_W +: CMD_W] !== want.command ||
            m_tdata[MODE_W + CMD_W +: STAMP_W] !== want.delay ||
            m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS) begin
            $display("result %0d expected: mode %0d valid %0b cmd %h delay %h last %0b",
                     results_seen, want.mode, want.valid, want.command, want.delay,
                     want.last);
            $display("result %0d actual:   mode %0d valid %0b cmd %h delay %h last %0b",
                     results_seen, m_tdata[MODE_W-1:0], m_tuser[0],
                     m_tdata[MODE_W +: CMD_W], m_tdata[MODE_W + CMD_W +: STAMP_W],
                     m_tlast);
          end
        end
      end
    end
  end

endmodule
